[rtl/core/outstanding_request_tag_tracker_top_assert.svh]
// Assertion macros shared by the tag tracker modules.
`ifndef OUTSTANDING_REQUEST_TAG_TRACKER_TOP_ASSERT_SVH
`define OUTSTANDING_REQUEST_TAG_TRACKER_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define ORTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ORTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[rtl/core/ortt_pkg.sv]
// Package with shared types and constants of the tag tracker.
`timescale 1ns / 1ps
package ortt_pkg;
	localparam int Capacity = 32;
	localparam int SlotW = 5;
	localparam int IdxW = 5;
	localparam int CntW = 6;
	localparam logic [15:0] InvalidId = 16'hFFFF;

	localparam logic [2:0] OpObtain = 3'd0;
	localparam logic [2:0] OpInval = 3'd1;
	localparam logic [2:0] OpResp = 3'd2;
	localparam logic [2:0] OpTick = 3'd3;
	localparam logic [2:0] OpClear = 3'd4;

	localparam logic [2:0] StOk = 3'd0;
	localparam logic [2:0] StDepleted = 3'd1;
	localparam logic [2:0] StInUse = 3'd2;
	localparam logic [2:0] StNoInst = 3'd3;
	localparam logic [2:0] StNotFound = 3'd4;

	localparam logic [3:0] OwnInvalid = 4'd0;
	localparam logic [3:0] OwnPending = 4'd1;
	localparam logic [3:0] OwnReady = 4'd2;
	localparam logic [3:0] OwnTimeout = 4'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_SEARCH, S_RD, S_CHK, S_SHIFT_RD, S_SHIFT_WR, S_APPEND, S_OUT
	} state_t;

	typedef struct packed {
		logic [7:0] owner;
		logic [15:0] id;
		logic [4:0] slot;
		logic [31:0] ts;
	} entry_t;

	// Controller to datapath.
	typedef struct packed {
		logic latch_in;
		logic clear;
		logic rd_en;
		logic [IdxW-1:0] rd_addr;
		logic shift_wr;
		logic [IdxW-1:0] wr_addr;
		logic append;
		logic free_slot;
		logic dec_count;
		logic [2:0] res_status;
		logic [1:0] res_kind;
		logic res_last;
		logic out_load;
		logic out_hold;
		logic out_release;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [2:0] op;
		logic pending;
		logic owner_hit;
		logic id_hit;
		logic expired;
		logic have_free;
		logic [CntW-1:0] count;
		logic out_busy;
	} dp_stat_t;

	localparam logic [1:0] KindReq = 2'd0;
	localparam logic [1:0] KindEntry = 2'd1;
	localparam logic [1:0] KindIssue = 2'd2;
endpackage

[rtl/core/ortt_ctrl.sv]
// Controller state machine of the tag tracker.
`timescale 1ns / 1ps
`include "outstanding_request_tag_tracker_top_assert.svh"
module ortt_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  ortt_pkg::dp_stat_t stat,
	output ortt_pkg::dp_cmd_t cmd
);
	import ortt_pkg::*;

	state_t state_q, state_d;
	logic [IdxW-1:0] idx_q, idx_d;
	logic [IdxW-1:0] pos_q, pos_d;
	logic [CntW-1:0] ticks_q, ticks_d;
	logic found_q, found_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			pos_q <= '0;
			ticks_q <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			pos_q <= pos_d;
			ticks_q <= ticks_d;
			found_q <= found_d;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		pos_d = pos_q;
		ticks_d = ticks_q;
		found_d = found_q;
		cmd = '0;
		in_ready = 1'b0;
		cmd.rd_addr = idx_q;
		cmd.wr_addr = idx_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					idx_d = '0;
					ticks_d = '0;
					found_d = 1'b0;
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (stat.op == OpClear) begin
					cmd.clear = 1'b1;
					state_d = S_IDLE;
				end else if (stat.op > OpClear) begin
					state_d = S_IDLE;
				end else if ({1'b0, idx_q} >= stat.count) begin
					// Search done without a match.
					if (stat.op == OpTick) begin
						state_d = S_IDLE;
					end else if (stat.op == OpObtain) begin
						state_d = stat.pending ? S_OUT : S_APPEND;
					end else begin
						state_d = S_OUT;
					end
				end else begin
					cmd.rd_en = 1'b1;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.op == OpTick) begin
					cmd.out_release = (ticks_q != '0);
					if (stat.expired && ticks_q != CntW'(Capacity)) begin
						found_d = 1'b1;
						pos_d = '0;
						state_d = S_OUT;
					end else begin
						cmd.res_last = 1'b1;
						state_d = S_IDLE;
					end
				end else if ((stat.op == OpResp) ? stat.id_hit : stat.owner_hit) begin
					found_d = 1'b1;
					pos_d = idx_q;
					state_d = S_OUT;
				end else begin
					idx_d = idx_q + 1'b1;
					if ({1'b0, idx_q} + 1'b1 >= stat.count) begin
						state_d = (stat.op == OpObtain) ? S_APPEND : S_OUT;
						if (stat.op == OpObtain && stat.pending) begin
							state_d = S_OUT;
						end
					end else begin
						state_d = S_SEARCH;
					end
				end
			end
			S_OUT: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					if (found_q) begin
						cmd.res_kind = KindEntry;
						cmd.res_status = StOk;
						cmd.free_slot = 1'b1;
						cmd.out_hold = (stat.op == OpTick);
						if (stat.op == OpObtain) begin
							idx_d = pos_q;
							cmd.out_load = 1'b0;
							state_d = S_SHIFT_RD;
						end else begin
							idx_d = pos_q;
							state_d = S_SHIFT_RD;
						end
					end else begin
						cmd.res_kind = KindReq;
						unique case (stat.op)
							OpObtain: cmd.res_status = stat.pending ? StInUse : StDepleted;
							OpInval: cmd.res_status = StNoInst;
							default: cmd.res_status = StNotFound;
						endcase
						state_d = S_IDLE;
					end
					if (stat.op == OpObtain && !found_q && !stat.pending &&
							!stat.have_free) begin
						cmd.res_status = StDepleted;
					end
				end
			end
			S_SHIFT_RD: begin
				if ({1'b0, idx_q} + 1'b1 >= stat.count) begin
					cmd.dec_count = 1'b1;
					found_d = 1'b0;
					if (stat.op == OpObtain) begin
						state_d = S_APPEND;
					end else if (stat.op == OpTick) begin
						ticks_d = ticks_q + 1'b1;
						idx_d = '0;
						state_d = S_RD;
					end else begin
						state_d = S_IDLE;
					end
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_addr = idx_q + 1'b1;
					state_d = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				idx_d = idx_q + 1'b1;
				state_d = S_SHIFT_RD;
			end
			S_RD: begin
				// Next tick candidate is the head entry.
				if (stat.count == '0) begin
					cmd.out_release = 1'b1;
					cmd.res_last = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_addr = '0;
					state_d = S_CHK;
				end
			end
			S_APPEND: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					if (stat.have_free) begin
						cmd.append = 1'b1;
						cmd.res_kind = KindIssue;
						cmd.res_status = StOk;
					end else begin
						cmd.res_kind = KindReq;
						cmd.res_status = StDepleted;
					end
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	`ORTT_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, state_q == S_IDLE, "ready outside idle")
	`ORTT_ASSERT_IMP(a_one_op, clk, arst_n, cmd.append, !cmd.shift_wr && !cmd.clear, "append clash")
	`ORTT_ASSERT_NEXT(a_accept, clk, arst_n, in_valid && in_ready, state_q == S_SEARCH, "no start")
endmodule

[rtl/core/ortt_dp.sv]
// Datapath of the tag tracker: entry table, slot bitmap, id counter, output word.
`timescale 1ns / 1ps
`include "outstanding_request_tag_tracker_top_assert.svh"
module ortt_dp (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic [2:0] operation,
	input  logic [7:0] owner_id,
	input  logic owner_pending,
	input  logic [15:0] request_id,
	input  logic has_error,
	input  logic [3:0] error_state,
	input  logic [31:0] now,
	input  ortt_pkg::dp_cmd_t cmd,
	output ortt_pkg::dp_stat_t stat,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] status,
	output logic [15:0] out_request_id,
	output logic [4:0] out_slot,
	output logic [7:0] out_owner,
	output logic [3:0] owner_state,
	output logic last
);
	import ortt_pkg::*;

	entry_t mem [Capacity];
	entry_t rd_q;
	logic [31:0] timeout_q;
	logic [Capacity-1:0] bitmap_q;
	logic [CntW-1:0] count_q;
	logic [15:0] next_id_q;
	logic [2:0] op_q;
	logic [7:0] owner_q;
	logic pending_q;
	logic [15:0] rid_q;
	logic err_q;
	logic [3:0] errst_q;
	logic [31:0] now_q;
	logic out_valid_q;
	logic [SlotW-1:0] free_idx;
	logic have_free;
	logic [31:0] age;

	always_comb begin
		free_idx = '0;
		have_free = 1'b0;
		for (int i = Capacity - 1; i >= 0; i--) begin
			if (!bitmap_q[i]) begin
				free_idx = SlotW'(i);
				have_free = 1'b1;
			end
		end
		if (count_q >= CntW'(Capacity)) have_free = 1'b0;
	end

	assign age = rd_q.ts - now_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q <= operation;
			owner_q <= owner_id;
			pending_q <= owner_pending;
			rid_q <= request_id;
			err_q <= has_error;
			errst_q <= error_state;
			now_q <= now;
		end
		if (cmd.rd_en) rd_q <= mem[cmd.rd_addr];
		if (cmd.shift_wr) mem[cmd.wr_addr] <= rd_q;
		if (cmd.append) mem[count_q[IdxW-1:0]] <= '{owner: owner_q, id: next_id_q,
			slot: free_idx, ts: now_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= '0;
			bitmap_q <= '0;
			count_q <= '0;
			next_id_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) timeout_q <= cfg_wdata;
			if (cmd.clear) begin
				bitmap_q <= '0;
				count_q <= '0;
				next_id_q <= '0;
			end
			if (cmd.free_slot) bitmap_q[rd_q.slot] <= 1'b0;
			if (cmd.dec_count) count_q <= count_q - 1'b1;
			if (cmd.append) begin
				bitmap_q[free_idx] <= 1'b1;
				count_q <= count_q + 1'b1;
				next_id_q <= (next_id_q == InvalidId - 16'd1) ? '0 : next_id_q + 16'd1;
			end
			if ((cmd.out_load && !cmd.out_hold) || cmd.out_release) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) last <= 1'b0;
		else if (cmd.out_release) last <= cmd.res_last;
		if (cmd.out_load) begin
			status <= cmd.res_status;
			unique case (cmd.res_kind)
				KindEntry: begin
					out_slot <= rd_q.slot;
					out_owner <= rd_q.owner;
					if (op_q == OpInval) begin
						out_request_id <= InvalidId;
						owner_state <= OwnInvalid;
					end else if (op_q == OpResp) begin
						out_request_id <= rd_q.id;
						owner_state <= err_q ? errst_q : OwnReady;
					end else begin
						out_request_id <= rd_q.id;
						owner_state <= OwnTimeout;
					end
				end
				KindIssue: begin
					out_request_id <= next_id_q;
					out_slot <= free_idx;
					out_owner <= owner_q;
					owner_state <= OwnPending;
				end
				default: begin
					out_request_id <= InvalidId;
					out_slot <= '0;
					out_owner <= (op_q == OpResp) ? 8'd0 : owner_q;
					owner_state <= (cmd.res_status == StInUse) ? OwnPending : OwnInvalid;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		stat.op = op_q;
		stat.pending = pending_q;
		stat.owner_hit = rd_q.owner == owner_q;
		stat.id_hit = rd_q.id == rid_q;
		stat.expired = age > timeout_q;
		stat.have_free = have_free;
		stat.count = count_q;
		stat.out_busy = out_valid_q && !out_ready;
	end

	`ORTT_ASSERT_IMP(a_count, clk, arst_n, 1'b1, count_q <= CntW'(Capacity), "count overflow")
	`ORTT_ASSERT_IMP(a_append_free, clk, arst_n, cmd.append, have_free, "append without slot")
	`ORTT_ASSERT_IMP(a_release, clk, arst_n, cmd.out_release, !out_valid_q, "release over word")
	`ORTT_ASSERT_IMP(a_id, clk, arst_n, 1'b1, next_id_q != InvalidId, "invalid id issued")
endmodule

[rtl/core/outstanding_request_tag_tracker_top.sv]
// Top level of the outstanding request tag tracker.
`timescale 1ns / 1ps
// Tracks up to 32 outstanding requests in an ordered table held in a small memory
// that is scanned one entry at a time. An operation steps through the table entry by
// entry, whether searched or moved up after a removal; a tick repeats this once per
// expired entry. Each tick result is held until the next head entry has been
// checked, so that the final one carries m_tlast. A result word that waits on m_tready
// stalls the block. The block takes one word at a time and takes the next only after
// the previous is done.
module outstanding_request_tag_tracker_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic s_tvalid,
	output logic s_tready,
	// operation, owner_id, owner_pending, request_id, has_error, error_state, now
	input  logic [71:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// status, out_request_id, out_slot, out_owner, owner_state
	output logic [39:0] m_tdata,
	output logic m_tlast
);
	import ortt_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;
	logic [2:0] status;
	logic [15:0] rid;
	logic [4:0] slot;
	logic [7:0] own;
	logic [3:0] ost;

	ortt_ctrl u_ctrl (.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .stat, .cmd);

	ortt_dp u_dp (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.operation(s_tdata[2:0]), .owner_id(s_tdata[10:3]), .owner_pending(s_tdata[11]),
		.request_id(s_tdata[27:12]), .has_error(s_tdata[28]), .error_state(s_tdata[32:29]),
		.now(s_tdata[64:33]), .cmd, .stat, .out_valid(m_tvalid), .out_ready(m_tready),
		.status, .out_request_id(rid), .out_slot(slot), .out_owner(own),
		.owner_state(ost), .last(m_tlast)
	);

	assign m_tdata = {4'd0, ost, own, slot, rid, status};
endmodule

[bench/tb_outstanding_request_tag_tracker_top.sv]
// Self-checking testbench for the outstanding request tag tracker.
`timescale 1ns / 1ps
module tb_outstanding_request_tag_tracker_top;
	import ortt_pkg::*;

	typedef struct {
		logic [2:0] status;
		logic [15:0] id;
		logic [4:0] slot;
		logic [7:0] owner;
		logic [3:0] state;
		logic last;
	} tag_result_t;

	localparam int IdleNone = 0;
	localparam int IdleSend = 1;
	localparam int IdleRecv = 2;
	localparam int IdleBoth = 3;
	localparam logic [2:0] OpBad5 = 3'd5;
	localparam logic [2:0] OpBad7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [71:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic m_tlast;

	tag_result_t expected_results[$];
	int error_count = 0;
	int idle_mode = IdleNone;

	logic [7:0] tracked_owner[Capacity];
	logic [15:0] tracked_id[Capacity];
	logic [4:0] tracked_slot[Capacity];
	logic [31:0] tracked_ts[Capacity];
	int tracked_count = 0;
	logic [31:0] slot_map = '0;
	logic [15:0] issue_counter = '0;
	logic [31:0] timeout_window = '0;
	logic [31:0] time_base = '0;

	outstanding_request_tag_tracker_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (idle_mode == IdleRecv)
			m_tready = ($urandom_range(99) >= 49);
		else if (idle_mode == IdleBoth)
			m_tready = ($urandom_range(99) >= 20);
		else
			m_tready = 1'b1;
	end

	function automatic void push_result(logic [2:0] st, logic [15:0] id, logic [4:0] sl,
			logic [7:0] ow, logic [3:0] os);
		tag_result_t r;
		r.status = st;
		r.id = id;
		r.slot = sl;
		r.owner = ow;
		r.state = os;
		r.last = 1'b0;
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic void drop_entry(int pos);
		slot_map[tracked_slot[pos]] = 1'b0;
		for (int j = pos; j + 1 < tracked_count; j++) begin
			tracked_owner[j] = tracked_owner[j + 1];
			tracked_id[j] = tracked_id[j + 1];
			tracked_slot[j] = tracked_slot[j + 1];
			tracked_ts[j] = tracked_ts[j + 1];
		end
		tracked_count--;
	endfunction

	function automatic int owner_position(logic [7:0] ow);
		for (int i = 0; i < tracked_count; i++)
			if (tracked_owner[i] == ow)
				return i;
		return -1;
	endfunction

	// Works out the results of one accepted word and updates the tracked table.
	function automatic void predict_tracker(logic [2:0] op, logic [7:0] ow, logic pend,
			logic [15:0] rid, logic herr, logic [3:0] err, logic [31:0] now);
		int pos;
		int s;
		int k;
		logic [4:0] sl;
		logic [7:0] o;
		case (op)
			OpObtain: begin
				pos = owner_position(ow);
				if (pos >= 0) begin
					drop_entry(pos);
				end else if (pend) begin
					push_result(StInUse, InvalidId, 5'd0, ow, OwnPending);
					return;
				end
				s = 0;
				while (s < Capacity && slot_map[s])
					s++;
				if (s >= Capacity || tracked_count >= Capacity) begin
					push_result(StDepleted, InvalidId, 5'd0, ow, OwnInvalid);
					return;
				end
				slot_map[s] = 1'b1;
				tracked_owner[tracked_count] = ow;
				tracked_id[tracked_count] = issue_counter;
				tracked_slot[tracked_count] = s[4:0];
				tracked_ts[tracked_count] = now;
				tracked_count++;
				push_result(StOk, issue_counter, s[4:0], ow, OwnPending);
				issue_counter = issue_counter + 16'd1;
				if (issue_counter == InvalidId)
					issue_counter = '0;
			end
			OpInval: begin
				pos = owner_position(ow);
				if (pos < 0) begin
					push_result(StNoInst, InvalidId, 5'd0, ow, OwnInvalid);
				end else begin
					sl = tracked_slot[pos];
					drop_entry(pos);
					push_result(StOk, InvalidId, sl, ow, OwnInvalid);
				end
			end
			OpResp: begin
				pos = -1;
				for (int i = 0; i < tracked_count && pos < 0; i++)
					if (tracked_id[i] == rid)
						pos = i;
				if (pos < 0) begin
					push_result(StNotFound, InvalidId, 5'd0, 8'd0, OwnInvalid);
				end else begin
					sl = tracked_slot[pos];
					o = tracked_owner[pos];
					drop_entry(pos);
					push_result(StOk, rid, sl, o, herr ? err : OwnReady);
				end
			end
			OpTick: begin
				k = 0;
				while (tracked_count > 0 && k < Capacity &&
						(tracked_ts[0] - now) > timeout_window) begin
					push_result(StOk, tracked_id[0], tracked_slot[0], tracked_owner[0],
						OwnTimeout);
					drop_entry(0);
					k++;
				end
				if (k > 0)
					expected_results[expected_results.size() - 1].last = 1'b1;
			end
			OpClear: begin
				tracked_count = 0;
				slot_map = '0;
				issue_counter = '0;
			end
			default: begin
			end
		endcase
	endfunction

	always @(posedge clk) begin
		tag_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("Unexpected result word %h last %b", m_tdata, m_tlast);
			end else begin
				e = expected_results.pop_front();
				if (m_tdata[2:0] !== e.status || m_tdata[18:3] !== e.id ||
						m_tdata[23:19] !== e.slot || m_tdata[31:24] !== e.owner ||
						m_tdata[35:32] !== e.state || m_tlast !== e.last) begin
					error_count++;
					if (error_count <= 10)
						$display({"Mismatch: expected status %0d id %0d slot %0d owner %0d ",
							"state %0d last %b, got %0d %0d %0d %0d %0d %b"},
							e.status, e.id, e.slot, e.owner, e.state, e.last,
							m_tdata[2:0], m_tdata[18:3], m_tdata[23:19], m_tdata[31:24],
							m_tdata[35:32], m_tlast);
				end
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(logic [2:0] op, logic [7:0] ow, logic pend, logic [15:0] rid,
			logic herr, logic [3:0] err, logic [31:0] now);
		int gap;
		gap = 0;
		if (idle_mode == IdleSend && $urandom_range(99) < 49)
			gap = $urandom_range(1, 4);
		else if (idle_mode == IdleBoth && $urandom_range(99) < 20)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = {7'd0, now, err, herr, rid, pend, ow, op};
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_tracker(op, ow, pend, rid, herr, err, now);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_timeout(logic [31:0] value);
		wait_drained();
		cfg_wdata = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		timeout_window = value;
	endtask

	task automatic test_directed();
		idle_mode = IdleNone;
		write_timeout(32'd0);
		send_word(OpObtain, 8'd0, 1'b0, 16'd0, 1'b0, 4'd0, 32'd0);
		send_word(OpObtain, 8'd255, 1'b0, 16'd0, 1'b0, 4'd0, 32'hFFFF_FFFF);
		send_word(OpObtain, 8'd9, 1'b1, 16'd0, 1'b0, 4'd0, 32'd5);
		send_word(OpObtain, 8'd0, 1'b1, 16'd0, 1'b0, 4'd0, 32'd5);
		send_word(OpInval, 8'd255, 1'b0, 16'd0, 1'b0, 4'd0, 32'd0);
		send_word(OpInval, 8'd77, 1'b0, 16'd0, 1'b0, 4'd0, 32'd0);
		send_word(OpResp, 8'd0, 1'b0, tracked_id[0], 1'b1, 4'd15, 32'd0);
		send_word(OpResp, 8'd0, 1'b0, 16'd65534, 1'b0, 4'd0, 32'd0);
		send_word(OpObtain, 8'd3, 1'b0, 16'd0, 1'b0, 4'd0, 32'd10);
		send_word(OpObtain, 8'd4, 1'b0, 16'd0, 1'b0, 4'd0, 32'd10);
		send_word(OpObtain, 8'd5, 1'b0, 16'd0, 1'b0, 4'd0, 32'd20);
		send_word(OpResp, 8'd0, 1'b0, tracked_id[1], 1'b0, 4'd0, 32'd0);
		send_word(OpTick, 8'd0, 1'b0, 16'd0, 1'b0, 4'd0, 32'd10);
		send_word(OpTick, 8'd0, 1'b0, 16'd0, 1'b0, 4'd0, 32'd20);
		send_word(OpTick, 8'd0, 1'b0, 16'd0, 1'b0, 4'd0, 32'd20);
		send_word(OpBad5, 8'd1, 1'b1, 16'hFFFE, 1'b1, 4'd15, 32'hFFFF_FFFF);
		send_word(OpBad7, 8'd1, 1'b0, 16'd0, 1'b0, 4'd0, 32'd0);
		send_word(OpClear, 8'd0, 1'b0, 16'd0, 1'b0, 4'd0, 32'd0);
		for (int i = 0; i < Capacity; i++)
			send_word(OpObtain, 8'(100 + i), 1'b0, 16'd0, 1'b0, 4'd0, 32'(i));
		send_word(OpObtain, 8'd200, 1'b0, 16'd0, 1'b0, 4'd0, 32'd0);
		send_word(OpObtain, 8'd201, 1'b1, 16'd0, 1'b0, 4'd0, 32'd0);
		send_word(OpObtain, 8'd110, 1'b0, 16'd0, 1'b0, 4'd0, 32'd99);
		send_word(OpTick, 8'd0, 1'b0, 16'd0, 1'b0, 4'd0, 32'd1000);
	endtask

	// Re-issues one owner many times in a row.
	task automatic test_id_wrap();
		idle_mode = IdleNone;
		send_word(OpClear, 8'd0, 1'b0, 16'd0, 1'b0, 4'd0, 32'd0);
		for (int i = 0; i < 40; i++)
			send_word(OpObtain, 8'd7, 1'b0, 16'd0, 1'b0, 4'd0, 32'd0);
		send_word(OpClear, 8'd0, 1'b0, 16'd0, 1'b0, 4'd0, 32'd0);
	endtask

	task automatic test_random(int mode, logic [31:0] window, int count);
		int pick;
		logic [7:0] ow;
		logic [15:0] rid;
		logic [31:0] now;
		write_timeout(window);
		idle_mode = mode;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			time_base = time_base + $urandom_range(0, 20);
			ow = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 39));
			if (pick < 38) begin
				now = ($urandom_range(19) == 0) ? $urandom : time_base;
				send_word(OpObtain, ow, 1'($urandom_range(1)), 16'($urandom_range(65534)),
					1'($urandom_range(1)), 4'($urandom), now);
			end else if (pick < 52) begin
				send_word(OpInval, ow, 1'($urandom_range(1)), 16'($urandom_range(65534)),
					1'($urandom_range(1)), 4'($urandom), $urandom);
			end else if (pick < 74) begin
				if (tracked_count > 0 && $urandom_range(9) < 7)
					rid = tracked_id[$urandom_range(tracked_count - 1)];
				else
					rid = 16'($urandom_range(65534));
				send_word(OpResp, ow, 1'($urandom_range(1)), rid, 1'($urandom_range(1)),
					4'($urandom), $urandom);
			end else if (pick < 95) begin
				now = ($urandom_range(9) == 0) ? $urandom :
					time_base + $urandom_range(0, 200) - 100;
				send_word(OpTick, ow, 1'($urandom_range(1)), 16'($urandom_range(65534)),
					1'($urandom_range(1)), 4'($urandom), now);
			end else if (pick < 98) begin
				send_word(OpClear, ow, 1'b0, 16'd0, 1'b0, 4'd0, 32'd0);
			end else begin
				send_word(3'($urandom_range(5, 7)), ow, 1'($urandom_range(1)),
					16'($urandom), 1'($urandom_range(1)), 4'($urandom), $urandom);
			end
			if (n == count / 2)
				wait_drained();
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_id_wrap();
		test_random(IdleNone, 32'd0, 90);
		test_random(IdleSend, 32'hFFFF_FFFF, 90);
		test_random(IdleRecv, 32'd50, 90);
		test_random(IdleBoth, $urandom, 90);
		wait_drained();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#50ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/ortt_pkg.sv
rtl/core/ortt_ctrl.sv
rtl/core/ortt_dp.sv
rtl/core/outstanding_request_tag_tracker_top.sv
bench/tb_outstanding_request_tag_tracker_top.sv
